[rtl/tcw_pkg.sv]
// Shared constants, command types and helpers for the text console writer.
// No dependencies; every other file in rtl/ but tcw_ram imports this package.
package tcw_pkg;

   // Grid geometry and tab spacing
   localparam int COLS     = 20;
   localparam int ROWS     = 4;
   localparam int TAB_STOP = 4;

   // Field widths
   localparam int OP_W   = 2;
   localparam int CHAR_W = 8;
   localparam int COL_W  = 5;
   localparam int ROW_W  = 2;

   localparam int CELLS  = ROWS * COLS;
   localparam int ADDR_W = $clog2(CELLS);

   // Command queue depth between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QLVL_W = $clog2(QDEPTH + 1);

   // Request opcodes
   localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
   localparam logic [OP_W-1:0] OP_SETCUR = 2'd2;
   localparam logic [OP_W-1:0] OP_READ   = 2'd3;

   // Character codes with special meaning
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_NONE    = 8'h00;

   // Classified command kinds
   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] K_NOP    = 3'd0;
   localparam logic [KIND_W-1:0] K_PUT    = 3'd1;
   localparam logic [KIND_W-1:0] K_NL     = 3'd2;
   localparam logic [KIND_W-1:0] K_TAB    = 3'd3;
   localparam logic [KIND_W-1:0] K_RET    = 3'd4;
   localparam logic [KIND_W-1:0] K_CLEAR  = 3'd5;
   localparam logic [KIND_W-1:0] K_SETCUR = 3'd6;
   localparam logic [KIND_W-1:0] K_READ   = 3'd7;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAR_W-1:0] chr;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
   } cmd_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QLVL_W-1:0] level;
   } q_status_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CHAR_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

   // True when a column sits on a tab stop inside the row
   function automatic logic is_tab_stop(input logic [COL_W:0] c);
      logic r;
      r = 1'b0;
      for (int i = TAB_STOP; i < COLS; i += TAB_STOP) begin
         if (c == (COL_W+1)'(i)) r = 1'b1;
      end
      return r;
   endfunction

   // Linear grid address of a row and column
   function automatic logic [ADDR_W-1:0] grid_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      return ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
   endfunction

endpackage

[rtl/text_console_char_writer.sv]
// Top level of the text console writer: front end, command queue, back end, grid RAM.
// Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back and tcw_ram.
//
//   channel  direction  handshake             payload
//   req      in         req_tvalid/tready     tuser opcode, tdata char/column/row
//   rsp      out        rsp_tvalid/tready     tdata char/column/row/cursor shown
//   csr      in         csr_wr_en             csr_wr_data cursor enable
//
// Put, return, clear, set cursor and no-op finish at the edge that pops them from the
// queue; a read finishes in ST_READ after the pop, since the RAM read is registered.
// Newline and tab write one space a cycle through the single RAM write port, the last
// one held until the output is free, starting in ST_FILL after the pop: up to COLS
// spaces for a newline, up to TAB_STOP for a tab.
// Reset clears the cursor, the per-cell valid bits (grid reads as spaces) and the
// queue; clear drops all valid bits at once. A stalled response holds the back
// end while the two-entry queue keeps taking requests.
module text_console_char_writer import tcw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] char_code, [12:8] column, [14:13] row
   input  logic [7:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] cell_char, [12:8] cursor_column,
                                    // [14:13] cursor_row, [15] cursor_shown
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic         cursor_en_ff;
   logic         q_push, q_pop;
   cmd_type      q_wr_cmd, q_rd_cmd;
   q_status_type q_stat;
   ram_req_type  ram_req;
   logic [CHAR_W-1:0] ram_rd_data;

   // Cursor enable register
   always_ff @(posedge clock) begin
      if (reset) cursor_en_ff <= 1'b0;
      else if (csr_wr_en) cursor_en_ff <= csr_wr_data;
   end

   tcw_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser[OP_W-1:0]),
      .req_char   (req_tdata[7:0]),
      .req_column (req_tdata[12:8]),
      .req_row    (req_tdata[14:13]),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_wr_cmd   (q_wr_cmd)
   );

   tcw_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_cmd (q_wr_cmd),
      .pop    (q_pop),
      .rd_cmd (q_rd_cmd),
      .stat   (q_stat)
   );

   tcw_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_cmd         (q_rd_cmd),
      .q_stat        (q_stat),
      .q_pop         (q_pop),
      .cursor_enable (cursor_en_ff),
      .ram_req       (ram_req),
      .ram_rd_data   (ram_rd_data),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

   tcw_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (CELLS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   // Reported cursor column stays inside the row
   a_rsp_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_tdata[12:8]} < (COL_W+1)'(COLS)))
      else $error("cursor column out of range");

   // Grid writes stay inside the grid
   a_wr_addr_range: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> ({1'b0, ram_req.wr_addr} < (ADDR_W+1)'(CELLS)))
      else $error("grid write address out of range");

   // Back end never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("pop from empty queue");

   // Queue level never exceeds its depth
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.level <= QLVL_W'(QDEPTH))
      else $error("queue level overflow");

endmodule

[rtl/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 80
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tcw_front.sv]
// Front end: takes request words, saturates coordinates, classifies the opcode.
// Depends on tcw_pkg.
module tcw_front import tcw_pkg::*; (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [CHAR_W-1:0] req_char,
   input  logic [COL_W-1:0]  req_column,
   input  logic [ROW_W-1:0]  req_row,
   input  q_status_type      q_stat,
   output logic              q_push,
   output cmd_type           q_wr_cmd
);

   // Accept whenever the queue has room
   assign req_tready = ~q_stat.full;
   assign q_push     = req_tvalid & ~q_stat.full;

   // Classify and clamp coordinates
   always_comb begin
      q_wr_cmd.chr = req_char;
      q_wr_cmd.col = ({1'b0, req_column} >= (COL_W+1)'(COLS)) ?
                     COL_W'(COLS - 1) : req_column;
      q_wr_cmd.row = ({1'b0, req_row} >= (ROW_W+1)'(ROWS)) ?
                     ROW_W'(ROWS - 1) : req_row;
      case (req_opcode)
         OP_PUT: begin
            case (req_char)
               CH_NONE:    q_wr_cmd.kind = K_NOP;
               CH_NEWLINE: q_wr_cmd.kind = K_NL;
               CH_TAB:     q_wr_cmd.kind = K_TAB;
               CH_RETURN:  q_wr_cmd.kind = K_RET;
               default:    q_wr_cmd.kind = K_PUT;
            endcase
         end
         OP_CLEAR:  q_wr_cmd.kind = K_CLEAR;
         OP_SETCUR: q_wr_cmd.kind = K_SETCUR;
         default:   q_wr_cmd.kind = K_READ;
      endcase
   end

endmodule

[rtl/tcw_queue.sv]
// Short command queue between the front end and the back end.
// Depends on tcw_pkg.
module tcw_queue import tcw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      wr_cmd,
   input  logic         pop,
   output cmd_type      rd_cmd,
   output q_status_type stat
);

   cmd_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0] level_ff, level_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      level_in  = level_ff;
      if (push & ~pop) level_in = level_ff + 1'b1;
      else if (pop & ~push) level_in = level_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Hold entries until they are popped
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= wr_cmd;
   end

   assign rd_cmd     = slot_ff[rd_ptr_ff];
   assign stat.full  = (level_ff == QLVL_W'(QDEPTH));
   assign stat.empty = (level_ff == '0);
   assign stat.level = level_ff;

endmodule

[rtl/tcw_back.sv]
// Back end: cursor, cell valid bits, fill sequencer and the response register.
// Depends on tcw_pkg; drives the grid RAM through a request struct.
module tcw_back import tcw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             q_cmd,
   input  q_status_type        q_stat,
   output logic                q_pop,
   input  logic                cursor_enable,
   output ram_req_type         ram_req,
   input  logic [CHAR_W-1:0]   ram_rd_data,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FILL = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              tab_ff, tab_in;
   logic              hit_ff, hit_in;
   logic [CELLS-1:0]  valid_ff, valid_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic              rsp_shown_ff;

   logic              out_free;
   logic              emit;
   logic [CHAR_W-1:0] emit_char;
   logic [COL_W:0]    col_inc;
   logic [ROW_W:0]    row_inc;
   logic [COL_W-1:0]  nxt_col;
   logic [ROW_W-1:0]  nxt_row;
   logic [ADDR_W-1:0] cur_addr;
   logic              fill_last;

   assign out_free = ~rsp_valid_ff | rsp_tready;

   // Cursor advance with wrap to the next row and back to the top
   always_comb begin
      col_inc = {1'b0, col_ff} + 1'b1;
      row_inc = {1'b0, row_ff} + 1'b1;
      if (col_inc == (COL_W+1)'(COLS)) begin
         nxt_col = '0;
         nxt_row = (row_inc == (ROW_W+1)'(ROWS)) ? '0 : row_inc[ROW_W-1:0];
      end else begin
         nxt_col = col_inc[COL_W-1:0];
         nxt_row = row_ff;
      end
      cur_addr  = grid_addr(row_ff, col_ff);
      fill_last = (col_inc == (COL_W+1)'(COLS)) | (tab_ff & is_tab_stop(col_inc));
   end

   // Command sequencer
   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      tab_in    = tab_ff;
      hit_in    = hit_ff;
      valid_in  = valid_ff;
      q_pop     = 1'b0;
      emit      = 1'b0;
      emit_char = '0;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = cur_addr;
      ram_req.wr_data = CH_SPACE;
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = grid_addr(q_cmd.row, q_cmd.col);
      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               case (q_cmd.kind)
                  K_NL, K_TAB: begin
                     q_pop    = 1'b1;
                     tab_in   = (q_cmd.kind == K_TAB);
                     state_in = ST_FILL;
                  end
                  K_READ: begin
                     q_pop         = 1'b1;
                     ram_req.rd_en = 1'b1;
                     hit_in        = valid_ff[ram_req.rd_addr];
                     state_in      = ST_READ;
                  end
                  default: begin
                     if (out_free) begin
                        q_pop = 1'b1;
                        emit  = 1'b1;
                        case (q_cmd.kind)
                           K_PUT: begin
                              ram_req.wr_en    = 1'b1;
                              ram_req.wr_data  = q_cmd.chr;
                              valid_in[cur_addr] = 1'b1;
                              col_in = nxt_col;
                              row_in = nxt_row;
                           end
                           K_RET: col_in = '0;
                           K_CLEAR: begin
                              valid_in = '0;
                              col_in   = '0;
                              row_in   = '0;
                           end
                           K_SETCUR: begin
                              col_in = q_cmd.col;
                              row_in = q_cmd.row;
                           end
                           default: ;
                        endcase
                     end
                  end
               endcase
            end
         end
         ST_FILL: begin
            // Write one space a cycle; stall the last one until the output is free
            if (!fill_last || out_free) begin
               ram_req.wr_en      = 1'b1;
               valid_in[cur_addr] = 1'b1;
               col_in = nxt_col;
               row_in = nxt_row;
               if (fill_last) begin
                  emit     = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = hit_ff ? ram_rd_data : CH_SPACE;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = emit | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         tab_ff       <= 1'b0;
         hit_ff       <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         tab_ff       <= tab_in;
         hit_ff       <= hit_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the response word when a command finishes
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_char_ff  <= emit_char;
         rsp_col_ff   <= col_in;
         rsp_row_ff   <= row_in;
         rsp_shown_ff <= cursor_enable;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_shown_ff, rsp_row_ff, rsp_col_ff, rsp_char_ff};

endmodule

[dv/tb_top.sv]
// Self-checking testbench for text_console_char_writer: directed table, then random phases.
// Depends on rtl/tcw_pkg.sv and rtl/text_console_char_writer.sv; predicts each response
// from a shadow copy of the character grid, the cursor and the cursor enable.
module tb_top import tcw_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] chr;
      logic [4:0] ccol;
      logic [1:0] crow;
      logic       shown;
   } screen_resp_type;

   typedef struct packed {
      logic [1:0]      op;
      logic [7:0]      ch;
      logic [4:0]      col;
      logic [1:0]      row;
      logic            typed;
      screen_resp_type resp;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [7:0] char_code, [12:8] column, [14:13] row
   logic [7:0]  req_tuser;   // [1:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] cell_char, [12:8] cursor_column,
                             // [14:13] cursor_row, [15] cursor_shown
   logic        csr_wr_en;
   logic        csr_wr_data;

   // Shadow state of the console
   logic [7:0]      scr_chars [COLS*ROWS];
   int              cur_x;
   int              cur_y;
   logic            cursor_en_shadow;
   screen_resp_type screen_resp_q [$];
   screen_resp_type exp_word;
   int              n_errors = 0;
   bit              steady = 1'b0;
   bit              hold_off_go = 1'b0;

   // Directed table; typed rows carry a response readable straight off the spec
   dir_row_type dir_tab [0:25] = '{
      '{OP_READ,   8'h00, 5'd0,  2'd0, 1'b1, '{8'h20, 5'd0,  2'd0, 1'b0}},
      '{OP_READ,   8'h00, 5'd31, 2'd3, 1'b1, '{8'h20, 5'd0,  2'd0, 1'b0}},
      '{OP_SETCUR, 8'h00, 5'd31, 2'd3, 1'b1, '{8'h00, 5'd19, 2'd3, 1'b0}},
      '{OP_PUT,    8'h5A, 5'd0,  2'd0, 1'b1, '{8'h00, 5'd0,  2'd0, 1'b0}},
      '{OP_READ,   8'h00, 5'd19, 2'd3, 1'b1, '{8'h5A, 5'd0,  2'd0, 1'b0}},
      '{OP_PUT,    8'hFF, 5'd0,  2'd0, 1'b0, '0},
      '{OP_PUT,    CH_NONE, 5'd0, 2'd0, 1'b0, '0},
      '{OP_PUT,    8'h01, 5'd0,  2'd0, 1'b0, '0},
      '{OP_PUT,    CH_TAB, 5'd0, 2'd0, 1'b0, '0},
      '{OP_PUT,    8'h61, 5'd0,  2'd0, 1'b0, '0},
      '{OP_PUT,    CH_NEWLINE, 5'd0, 2'd0, 1'b0, '0},
      '{OP_SETCUR, 8'h00, 5'd17, 2'd1, 1'b1, '{8'h00, 5'd17, 2'd1, 1'b0}},
      '{OP_PUT,    CH_TAB, 5'd0, 2'd0, 1'b1, '{8'h00, 5'd0,  2'd2, 1'b0}},
      '{OP_SETCUR, 8'h00, 5'd5,  2'd2, 1'b0, '0},
      '{OP_PUT,    CH_RETURN, 5'd0, 2'd0, 1'b1, '{8'h00, 5'd0, 2'd2, 1'b0}},
      '{OP_SETCUR, 8'h00, 5'd19, 2'd0, 1'b0, '0},
      '{OP_PUT,    CH_NEWLINE, 5'd0, 2'd0, 1'b1, '{8'h00, 5'd0, 2'd1, 1'b0}},
      '{OP_SETCUR, 8'h00, 5'd0,  2'd3, 1'b0, '0},
      '{OP_PUT,    CH_NEWLINE, 5'd0, 2'd0, 1'b1, '{8'h00, 5'd0, 2'd0, 1'b0}},
      '{OP_READ,   8'h00, 5'd19, 2'd3, 1'b0, '0},
      '{OP_PUT,    8'h80, 5'd0,  2'd0, 1'b0, '0},
      '{OP_CLEAR,  8'h00, 5'd0,  2'd0, 1'b1, '{8'h00, 5'd0,  2'd0, 1'b0}},
      '{OP_READ,   8'h00, 5'd0,  2'd0, 1'b1, '{8'h20, 5'd0,  2'd0, 1'b0}},
      '{OP_SETCUR, 8'h00, 5'd16, 2'd2, 1'b0, '0},
      '{OP_PUT,    CH_TAB, 5'd0, 2'd0, 1'b1, '{8'h00, 5'd0,  2'd3, 1'b0}},
      '{OP_READ,   8'h00, 5'd20, 2'd1, 1'b0, '0}
   };

   text_console_char_writer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      n_errors++;
   endtask

   function automatic void blank_screen();
      for (int i = 0; i < COLS*ROWS; i++) scr_chars[i] = CH_SPACE;
   endfunction

   // Move the cursor to the next row past the last column, row 0 past the last row
   function automatic void wrap_cursor();
      if (cur_x >= COLS) begin
         cur_x = 0;
         cur_y++;
      end
      if (cur_y >= ROWS) cur_y = 0;
   endfunction

   // Advance the shadow console by one command and return the response it produces
   function automatic screen_resp_type apply_console_cmd(input logic [1:0] op,
                                                         input logic [7:0] ch,
                                                         input logic [4:0] col,
                                                         input logic [1:0] row);
      screen_resp_type r;
      int cx, cy, tgt;
      r = '0;
      cx = (int'(col) >= COLS) ? COLS - 1 : int'(col);
      cy = (int'(row) >= ROWS) ? ROWS - 1 : int'(row);
      case (op)
         OP_PUT: begin
            wrap_cursor();
            if (ch == CH_NEWLINE || ch == CH_TAB) begin
               // fill with spaces to the row end or the next tab stop
               tgt = (ch == CH_NEWLINE) ? COLS : (cur_x / TAB_STOP + 1) * TAB_STOP;
               if (tgt > COLS) tgt = COLS;
               while (cur_x < tgt) begin
                  scr_chars[cur_y*COLS + cur_x] = CH_SPACE;
                  cur_x++;
               end
            end else if (ch == CH_RETURN) begin
               cur_x = 0;
            end else if (ch != CH_NONE) begin
               scr_chars[cur_y*COLS + cur_x] = ch;
               cur_x++;
            end
            wrap_cursor();
         end
         OP_CLEAR: begin
            blank_screen();
            cur_x = 0;
            cur_y = 0;
         end
         OP_SETCUR: begin
            cur_x = cx;
            cur_y = cy;
         end
         default: r.chr = scr_chars[cy*COLS + cx];
      endcase
      r.ccol  = 5'(cur_x);
      r.crow  = 2'(cur_y);
      r.shown = cursor_en_shadow;
      return r;
   endfunction

   // Offer one command word, hold it until taken, then queue its expected response
   task automatic send_cmd(input logic [1:0] op, input logic [7:0] ch, input logic [4:0] col,
                           input logic [1:0] row, input logic typed,
                           input screen_resp_type typed_resp);
      screen_resp_type pred;
      if (!steady) begin
         while ($urandom_range(99) < 28) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, row, col, ch};
      req_tuser  <= {6'd0, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = apply_console_cmd(op, ch, col, row);
      screen_resp_q.push_back(typed ? typed_resp : pred);
   endtask

   // Mostly text with control characters, plus cursor moves, reads and rare clears
   task automatic send_random_cmds(input int count);
      logic [1:0] op;
      logic [7:0] ch;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         op = (pick < 55) ? OP_PUT : (pick < 75) ? OP_READ : (pick < 95) ? OP_SETCUR : OP_CLEAR;
         pick = $urandom_range(99);
         ch = (pick < 10) ? CH_NEWLINE : (pick < 18) ? CH_TAB : (pick < 23) ? CH_RETURN :
              (pick < 27) ? CH_NONE : 8'($urandom_range(255));
         send_cmd(op, ch, 5'($urandom_range(31)), 2'($urandom_range(3)), 1'b0, '0);
      end
   endtask

   // Drop valid and hold until every queued response has come back
   task automatic finish_phase();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (screen_resp_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_cursor_enable(input logic en);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= en;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cursor_en_shadow = en;
   endtask

   // Sender: reset, directed table, then three random phases under different settings
   initial begin : stimulus
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 1'b0;
      blank_screen();
      cur_x = 0;
      cur_y = 0;
      cursor_en_shadow = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_tab[i])
         send_cmd(dir_tab[i].op, dir_tab[i].ch, dir_tab[i].col, dir_tab[i].row,
                  dir_tab[i].typed, dir_tab[i].resp);
      finish_phase();
      write_cursor_enable(1'b1);
      send_random_cmds(150);
      finish_phase();
      // back-to-back words while the response side holds off
      write_cursor_enable(1'b0);
      steady = 1'b1;
      hold_off_go = 1'b1;
      send_random_cmds(100);
      finish_phase();
      steady = 1'b0;
      write_cursor_enable(1'b1);
      send_random_cmds(150);
      finish_phase();
      repeat (2*COLS + 10) @(posedge clock);
      if (n_errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Receiver: random backpressure, one long hold-off, no stalls in steady stretches
   initial begin : rsp_side
      int hold_left;
      bit hold_off_done;
      hold_left = 0;
      hold_off_done = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go && !hold_off_done) begin
            hold_off_done = 1'b1;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 28);
         end
      end
   end

   // Compare each accepted response word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (screen_resp_q.size() == 0) begin
            report_mismatch("response word with nothing pending, data", rsp_tdata, 0);
         end else begin
            exp_word = screen_resp_q.pop_front();
            if (rsp_tdata[7:0] !== exp_word.chr)
               report_mismatch("cell_char", rsp_tdata[7:0], exp_word.chr);
            if (rsp_tdata[12:8] !== exp_word.ccol)
               report_mismatch("cursor_column", rsp_tdata[12:8], exp_word.ccol);
            if (rsp_tdata[14:13] !== exp_word.crow)
               report_mismatch("cursor_row", rsp_tdata[14:13], exp_word.crow);
            if (rsp_tdata[15] !== exp_word.shown)
               report_mismatch("cursor_shown", rsp_tdata[15], exp_word.shown);
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      #1ms;
      $display("simulation failed");
      $finish;
   end

endmodule

[sim.f]
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_console_char_writer.sv
dv/tb_top.sv
